// ----- src/ffpa_pkg.sv -----
package ffpa_pkg;

   // pool ceiling; port widths are built around a 64 KiB pool
   localparam int POOL_MAX_BYTES = 65536;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_SPACE    = 2'd1,
      ST_BAD_ARGS    = 2'd2,
      ST_BAD_POINTER = 2'd3
   } ffpa_status_type;

   typedef enum logic [3:0] {
      S_SETUP,
      S_INIT_WR,
      S_IDLE,
      S_RD,
      S_CHK,
      S_RD_NEXT,
      S_CHK_NEXT,
      S_WR_SPLIT,
      S_MERGE,
      S_RESP
   } ffpa_state_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

endpackage

// ----- src/ffpa_header_ram.sv -----
module ffpa_header_ram #(
   parameter int DEPTH = 16387,
   parameter int IW    = 15,
   parameter int DATW  = 18
) (
   input  logic            clock,
   input  logic [IW-1:0]   rd_addr,
   output logic [DATW-1:0] rd_data,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  logic [DATW-1:0] wr_data
);

   logic [DATW-1:0] mem [DEPTH];
   logic [DATW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/first_fit_pool_allocator.sv -----
// First-fit pool allocator with coalescing.
//
// Request channel (req_*): one word per allocate or free. Response channel
// (rsp_*): one word per request, status plus user-area offset (zero unless
// an allocate succeeded). Both use valid/stall; the receiver drives stall.
// csr_write_enable/csr_write_data set the pool size; the pool is rebuilt as
// one free chunk, so every block is forgotten. Write it only while idle.
//
// Chunk headers live in a single-port-read RAM indexed by offset/4. Each
// request walks the address-ordered chunk chain from offset 0, chunk by
// chunk (read, then check). A miss or a bad pointer goes to the response
// once found; a successful allocate first writes the split, a free of the
// last chunk first writes the merge, and a free with a right neighbour
// first reads and checks that neighbour, then writes the merge. Early
// rejects (not ready, zero size, null or low pointer) go straight to the
// response. Requests are served one at a time; req_stall is high while a
// request is in progress, and the block goes back to idle when the
// response word is loaded.
//
// Reset (synchronous) loads a pool size of 65536 and runs set-up: the size
// is rounded up to whole pages one page at a time, capped at 65536, then
// the first header is written.
// A response word waits in the output register while rsp_stall is high; a
// later finished response waits in S_RESP, with req_stall high, until then.
module first_fit_pool_allocator
   import ffpa_pkg::*;
#(
   parameter int PAGE_BYTES     = 4096,
   parameter int HEADER_BYTES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [16:0] req_request_bytes,
   input  logic [15:0] req_block_offset,
   input  logic        req_null_pointer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_block_address
);

   localparam int SW    = $clog2(POOL_MAX_BYTES + 1);
   localparam int OW    = $clog2(POOL_MAX_BYTES + HEADER_BYTES + 1);
   localparam int DW    = (OW + 2 > 19) ? OW + 2 : 19;
   localparam int DEPTH = (POOL_MAX_BYTES + HEADER_BYTES) / 4 + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int DATW  = SW + 1;

   localparam logic [DW-1:0] HDR  = DW'(HEADER_BYTES);
   localparam logic [DW-1:0] PAGE = DW'(PAGE_BYTES);
   localparam logic [DW-1:0] PMAX = DW'(POOL_MAX_BYTES);
   localparam logic [16:0]   RESET_POOL = 17'd65536;

   ffpa_state_type state_ff, state_in;

   logic [16:0]    pool_req_ff, pool_req_in;
   logic [DW-1:0]  acc_ff, acc_in;        // page-rounding accumulator
   logic [DW-1:0]  end_ff, end_in;        // offset just past the last chunk
   logic           ready_ff, ready_in;

   logic           op_ff, op_in;
   logic [DW-1:0]  need_ff, need_in;      // rounded request + header
   logic [DW-1:0]  rreq_ff, rreq_in;      // rounded request
   logic [DW-1:0]  target_ff, target_in;  // header offset to free
   logic [DW-1:0]  cur_ff, cur_in;
   logic [DW-1:0]  cur_size_ff, cur_size_in;
   logic [DW-1:0]  nxt_ff, nxt_in;
   logic           prev_ok_ff, prev_ok_in;
   logic           prev_free_ff, prev_free_in;
   logic [DW-1:0]  prev_ff, prev_in;
   logic [DW-1:0]  prev_size_ff, prev_size_in;
   logic           right_free_ff, right_free_in;
   logic [DW-1:0]  right_size_ff, right_size_in;

   ffpa_status_type res_st_ff, res_st_in;
   logic [15:0]     res_addr_ff, res_addr_in;

   logic            rsp_valid_ff, rsp_valid_in;
   ffpa_status_type rsp_st_ff, rsp_st_in;
   logic [15:0]     rsp_addr_ff, rsp_addr_in;

   // RAM
   logic [IW-1:0]   rd_addr;
   logic [DATW-1:0] rd_data;
   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   logic [DATW-1:0] wr_data;

   logic            rd_taken;
   logic [DW-1:0]   rd_size;
   logic [DW-1:0]   walk_next;
   logic [DW-1:0]   merge_size;
   logic [DW-1:0]   split_off;

   assign rd_taken   = rd_data[SW];
   assign rd_size    = DW'(rd_data[SW-1:0]);
   assign walk_next  = cur_ff + HDR + rd_size;
   assign split_off  = cur_ff + need_ff;
   assign merge_size = ((prev_ok_ff && prev_free_ff) ? prev_size_ff + HDR : '0)
                     + cur_size_ff
                     + (right_free_ff ? HDR + right_size_ff : '0);

   ffpa_header_ram #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .DATW  (DATW)
   ) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SETUP;
         pool_req_ff  <= RESET_POOL;
         acc_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_req_ff  <= pool_req_in;
         acc_ff       <= acc_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff        <= end_in;
      op_ff         <= op_in;
      need_ff       <= need_in;
      rreq_ff       <= rreq_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      cur_size_ff   <= cur_size_in;
      nxt_ff        <= nxt_in;
      prev_ok_ff    <= prev_ok_in;
      prev_free_ff  <= prev_free_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      right_free_ff <= right_free_in;
      right_size_ff <= right_size_in;
      res_st_ff     <= res_st_in;
      res_addr_ff   <= res_addr_in;
      rsp_st_ff     <= rsp_st_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // next state and datapath
   always_comb begin
      logic [DW-1:0] req_ext;
      logic [DW-1:0] rounded;
      logic [DW-1:0] v_ext;
      req_ext = DW'(req_request_bytes);
      rounded = (req_ext + DW'(3)) & ~DW'(3);
      v_ext   = DW'(pool_req_ff);

      state_in      = state_ff;
      pool_req_in   = pool_req_ff;
      acc_in        = acc_ff;
      end_in        = end_ff;
      ready_in      = ready_ff;
      op_in         = op_ff;
      need_in       = need_ff;
      rreq_in       = rreq_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      cur_size_in   = cur_size_ff;
      nxt_in        = nxt_ff;
      prev_ok_in    = prev_ok_ff;
      prev_free_in  = prev_free_ff;
      prev_in       = prev_ff;
      prev_size_in  = prev_size_ff;
      right_free_in = right_free_ff;
      right_size_in = right_size_ff;
      res_st_in     = res_st_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_st_in     = rsp_st_ff;
      rsp_addr_in   = rsp_addr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_SETUP: begin
            if (acc_ff >= v_ext || acc_ff >= PMAX) begin
               if (acc_ff > PMAX) begin
                  acc_in = PMAX;
               end
               state_in = S_INIT_WR;
            end else begin
               acc_in = acc_ff + PAGE;
            end
         end
         S_INIT_WR: begin
            ready_in = (acc_ff != '0);
            end_in   = acc_ff + HDR;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_operation;
               rreq_in      = rounded;
               need_in      = rounded + HDR;
               target_in    = DW'(req_block_offset) - HDR;
               cur_in       = '0;
               prev_ok_in   = 1'b0;
               res_addr_in  = '0;
               res_st_in    = ST_OK;
               state_in     = S_RD;
               if (req_operation == OP_ALLOC) begin
                  if (!ready_ff) begin
                     res_st_in = ST_NO_SPACE;
                     state_in  = S_RESP;
                  end else if (req_request_bytes == '0) begin
                     res_st_in = ST_BAD_ARGS;
                     state_in  = S_RESP;
                  end
               end else if (req_null_pointer) begin
                  state_in = S_RESP;
               end else if (!ready_ff || DW'(req_block_offset) < HDR) begin
                  res_st_in = ST_BAD_POINTER;
                  state_in  = S_RESP;
               end
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            nxt_in = walk_next;
            if (op_ff == OP_ALLOC) begin
               if (!rd_taken && rd_size >= need_ff) begin
                  cur_size_in = rd_size;
                  res_addr_in = 16'(cur_ff + HDR);
                  state_in    = S_WR_SPLIT;
               end else if (walk_next >= end_ff) begin
                  res_st_in = ST_NO_SPACE;
                  state_in  = S_RESP;
               end else begin
                  cur_in   = walk_next;
                  state_in = S_RD;
               end
            end else begin
               if (cur_ff == target_ff) begin
                  cur_size_in   = rd_size;
                  right_free_in = 1'b0;
                  if (rd_taken) begin
                     state_in = (walk_next < end_ff) ? S_RD_NEXT : S_MERGE;
                  end else begin
                     res_st_in = ST_BAD_POINTER;
                     state_in  = S_RESP;
                  end
               end else if (cur_ff > target_ff || walk_next >= end_ff) begin
                  res_st_in = ST_BAD_POINTER;
                  state_in  = S_RESP;
               end else begin
                  prev_ok_in   = 1'b1;
                  prev_free_in = !rd_taken;
                  prev_in      = cur_ff;
                  prev_size_in = rd_size;
                  cur_in       = walk_next;
                  state_in     = S_RD;
               end
            end
         end
         S_RD_NEXT: begin
            state_in = S_CHK_NEXT;
         end
         S_CHK_NEXT: begin
            right_free_in = !rd_taken;
            right_size_in = rd_size;
            state_in      = S_MERGE;
         end
         S_WR_SPLIT: begin
            state_in = S_RESP;
         end
         S_MERGE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_addr_in  = (res_st_ff == ST_OK && op_ff == OP_ALLOC) ? res_addr_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_SETUP;
         end
      endcase

      if (csr_write_enable) begin
         pool_req_in = csr_write_data;
         acc_in      = '0;
         ready_in    = 1'b0;
         state_in    = S_SETUP;
      end
   end

   // outputs and RAM controls
   always_comb begin
      rd_addr = (state_ff == S_RD_NEXT) ? nxt_ff[IW+1:2] : cur_ff[IW+1:2];
      wr_en   = 1'b0;
      wr_addr = cur_ff[IW+1:2];
      wr_data = '0;
      case (state_ff)
         S_INIT_WR: begin
            wr_en   = (acc_ff != '0);
            wr_addr = '0;
            wr_data = {1'b0, acc_ff[SW-1:0]};
         end
         S_CHK: begin
            // taken part of a split
            wr_en   = (op_ff == OP_ALLOC) && !rd_taken && rd_size >= need_ff;
            wr_data = {1'b1, rreq_ff[SW-1:0]};
         end
         S_WR_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = split_off[IW+1:2];
            wr_data = {1'b0, SW'(cur_size_ff - need_ff)};
         end
         S_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = (prev_ok_ff && prev_free_ff) ? prev_ff[IW+1:2] : cur_ff[IW+1:2];
            wr_data = {1'b0, merge_size[SW-1:0]};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      req_stall         = (state_ff != S_IDLE);
      rsp_valid         = rsp_valid_ff;
      rsp_status        = rsp_st_ff;
      rsp_block_address = rsp_addr_ff;
   end

endmodule

// ----- src/ffpa_checker.sv -----
module ffpa_checker
   import ffpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        csr_write_enable,
   input logic [16:0] csr_write_data,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic [16:0] req_request_bytes,
   input logic [15:0] req_block_offset,
   input logic        req_null_pointer,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_block_address
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_block_address))
      else $error("response word changed while stalled");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_block_address == '0)
      else $error("nonzero address on failed request");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

   a_setup_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("request taken during pool set-up");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);
